// ----- hw/rtl/rspc_pkg.sv -----
// Package for the random sphere placement checker: types, register codes and constants.
// No dependencies.
package rspc_pkg;

  localparam int unsigned CFG_AW = 5;

  typedef enum logic [2:0] {
    REG_BOX_X   = 3'd0,
    REG_BOX_Y   = 3'd1,
    REG_BOX_Z   = 3'd2,
    REG_WALL    = 3'd3,
    REG_RADIUS  = 3'd4,
    REG_GRACE   = 3'd5,
    REG_TARGET  = 3'd6,
    REG_TRIES   = 3'd7
  } reg_idx_t;

  localparam logic [23:0] ATT_MAX = 24'hFFFFFF;
  localparam logic [10:0] BOX_MAX = 11'd1024;

  // controller -> datapath commands
  typedef struct packed {
    logic start;    // latch trial, clear scan index
    logic coord;    // register the trial coordinates
    logic step;     // issue one stored-centre compare
    logic commit;   // write trial and bump counters
    logic idle_res; // result for a step after placement is over
  } rspc_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic active;    // placement still running
    logic scan_last; // last compare issued
    logic scan_none; // nothing stored to compare
    logic pipe_done; // compare pipeline drained
  } rspc_sts_t;

endpackage

// ----- hw/rtl/rspc_if.sv -----
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing.
interface rspc_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/random_sphere_placement_checker_unit.sv -----
// Random sequential sphere placement with an overlap test against every stored centre.
// One word in gives one word out. A trial runs the scaling multiply, then one centre
// read per cycle from the centre memory through a three-stage compare pipeline, then
// the commit. Steps after placement is over go straight to the result word.
// Depends on rspc_pkg, rspc_if, rspc_ctrl and rspc_dp.
module random_sphere_placement_checker_unit import rspc_pkg::*; #(
  parameter int unsigned MAX_SPHERES = 1024,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  rspc_if.sink              in_ch,
  rspc_if.source            out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  rspc_cmd_t cmd;
  rspc_sts_t sts;
  logic      we;
  reg_idx_t  idx;

  assign cfg_pready = 1'b1;
  assign we  = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx = reg_idx_t'(cfg_paddr[4:2]);

  // in word: {frac_x, frac_y, frac_z}; out word: {accepted, x, y, z, placed, reached, exhausted}
  logic [17:0] rx, ry, rz;
  logic [10:0] rp;
  logic        ra, rr, re;

  rspc_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  rspc_dp #(.MAX_SPHERES(MAX_SPHERES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n,
    .cfg_we(we), .cfg_idx(idx), .cfg_wdata(cfg_pwdata), .cfg_rdata(cfg_prdata),
    .frac_x(in_ch.data[47:32]), .frac_y(in_ch.data[31:16]), .frac_z(in_ch.data[15:0]),
    .cmd, .sts,
    .res_accepted(ra), .res_x(rx), .res_y(ry), .res_z(rz),
    .res_placed(rp), .res_reached(rr), .res_exhausted(re)
  );

  assign out_ch.data = {ra, rx, ry, rz, rp, rr, re};

endmodule

// ----- hw/rtl/rspc_ctrl.sv -----
// Controller state machine for the placement checker.
// Depends on rspc_pkg.
module rspc_ctrl import rspc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output rspc_cmd_t cmd,
  input  rspc_sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COORD = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_COMMIT= 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (sts.active) state_nxt = S_COORD;
          else begin
            cmd.idle_res = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_COORD: begin
        cmd.coord = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_none) state_nxt = S_DRAIN;
        else begin
          cmd.step = 1'b1;
          if (sts.scan_last) state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: if (sts.pipe_done) state_nxt = S_COMMIT;
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("word offered outside output state");
  a_no_cmd_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.start, cmd.coord, cmd.step, cmd.commit}) <= 1)
    else $error("overlapping commands");
  a_commit_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_OUT) else $error("commit not followed by result");

endmodule

// ----- hw/rtl/rspc_dp.sv -----
// Datapath: registers, trial scaling, centre memory and pipelined overlap compare.
// Depends on rspc_pkg.
module rspc_dp import rspc_pkg::*; #(
  parameter int unsigned MAX_SPHERES = 1024,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  reg_idx_t          cfg_idx,
  input  logic [31:0]       cfg_wdata,
  output logic [31:0]       cfg_rdata,
  input  logic [15:0]       frac_x,
  input  logic [15:0]       frac_y,
  input  logic [15:0]       frac_z,
  input  rspc_cmd_t         cmd,
  output rspc_sts_t         sts,
  output logic              res_accepted,
  output logic [17:0]       res_x,
  output logic [17:0]       res_y,
  output logic [17:0]       res_z,
  output logic [10:0]       res_placed,
  output logic              res_reached,
  output logic              res_exhausted
);

  localparam int unsigned AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned CW = $clog2(MAX_SPHERES + 1);
  localparam int unsigned LW = 11 + FRAC_BITS;       // coordinate width
  localparam int unsigned OW = 17;                   // radius+grace width
  localparam int unsigned MW = 18;                   // 2*radius+grace width
  localparam int unsigned SW = 2 * LW + 2;           // sum of squares width
  localparam int unsigned BW = CW + 14;              // target * tries width
  localparam logic [CW-1:0] MAXC = CW'(MAX_SPHERES);

  // configuration registers
  logic [10:0] box_x_r, box_y_r, box_z_r, tgt_r;
  logic [2:0]  wall_r;
  logic [15:0] radius_r, grace_r;
  logic [13:0] tries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= 11'd128; box_y_r <= 11'd128; box_z_r <= 11'd128;
      wall_r <= 3'd0; radius_r <= 16'd896; grace_r <= 16'd256;
      tgt_r <= 11'd1; tries_r <= 14'd10000;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_BOX_X:  box_x_r  <= cfg_wdata[10:0];
        REG_BOX_Y:  box_y_r  <= cfg_wdata[10:0];
        REG_BOX_Z:  box_z_r  <= cfg_wdata[10:0];
        REG_WALL:   wall_r   <= cfg_wdata[2:0];
        REG_RADIUS: radius_r <= cfg_wdata[15:0];
        REG_GRACE:  grace_r  <= cfg_wdata[15:0];
        REG_TARGET: tgt_r    <= cfg_wdata[10:0];
        REG_TRIES:  tries_r  <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BOX_X:  cfg_rdata = {21'd0, box_x_r};
      REG_BOX_Y:  cfg_rdata = {21'd0, box_y_r};
      REG_BOX_Z:  cfg_rdata = {21'd0, box_z_r};
      REG_WALL:   cfg_rdata = {29'd0, wall_r};
      REG_RADIUS: cfg_rdata = {16'd0, radius_r};
      REG_GRACE:  cfg_rdata = {16'd0, grace_r};
      REG_TARGET: cfg_rdata = {21'd0, tgt_r};
      REG_TRIES:  cfg_rdata = {18'd0, tries_r};
      default:    cfg_rdata = '0;
    endcase
  end

  // derived values
  function automatic logic [10:0] sat_box(input logic [10:0] l);
    if (l == 11'd0) return 11'd1;
    if (l > BOX_MAX) return BOX_MAX;
    return l;
  endfunction

  logic [LW-1:0] lq_x, lq_y, lq_z;
  logic [OW-1:0] off;
  logic [MW-1:0] lim;
  logic [CW-1:0] eff_tgt;
  logic [BW-1:0] budget_full;
  logic [23:0]   budget;

  assign lq_x = {sat_box(box_x_r), FRAC_BITS'(0)};
  assign lq_y = {sat_box(box_y_r), FRAC_BITS'(0)};
  assign lq_z = {sat_box(box_z_r), FRAC_BITS'(0)};
  assign off  = OW'(radius_r) + OW'(grace_r);
  assign lim  = {1'b0, radius_r, 1'b0} + MW'(grace_r);
  assign eff_tgt = (32'(tgt_r) > MAX_SPHERES) ? MAXC : CW'(tgt_r);
  assign budget_full = BW'(eff_tgt) * BW'(tries_r);
  assign budget = (budget_full > BW'(ATT_MAX)) ? ATT_MAX : 24'(budget_full);

  // counters
  logic [CW-1:0] placed_r;
  logic [23:0]   att_r;
  logic          active;
  assign active = (CW'(placed_r) < eff_tgt) && (att_r < budget);

  // latched fractions
  logic [15:0] fx_r, fy_r, fz_r;
  always_ff @(posedge clk) if (cmd.start) begin
    fx_r <= frac_x; fy_r <= frac_y; fz_r <= frac_z;
  end

  // trial scaling: one multiply per axis, registered
  function automatic logic [LW-1:0] scale(input logic [LW-1:0] lq, input logic w,
                                          input logic [15:0] f);
    logic [LW-1:0]  lo, span;
    logic [LW+15:0] p;
    lo = '0; span = lq;
    if (w) begin
      if ((LW+2)'({off, 1'b0}) > (LW+2)'(lq)) return lq >> 1;
      lo = LW'(off);
      span = lq - LW'({off, 1'b0});
    end
    p = span * f;
    return lo + p[LW+15:16];
  endfunction

  logic [LW-1:0] tx_r, ty_r, tz_r;
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tx_r <= '0; ty_r <= '0; tz_r <= '0;
    end else if (cmd.coord) begin
      tx_r <= scale(lq_x, wall_r[0], fx_r);
      ty_r <= scale(lq_y, wall_r[1], fy_r);
      tz_r <= scale(lq_z, wall_r[2], fz_r);
    end
  end

  // centre memory
  logic [LW-1:0] mem_x [MAX_SPHERES];
  logic [LW-1:0] mem_y [MAX_SPHERES];
  logic [LW-1:0] mem_z [MAX_SPHERES];
  logic [LW-1:0] rx_r, ry_r, rz_r;
  logic [CW-1:0] idx_r;
  logic          ok_r;
  logic          accept_now;

  assign accept_now = ok_r && (placed_r < MAXC);

  always_ff @(posedge clk) begin
    if (cmd.commit && accept_now) begin
      mem_x[placed_r[AW-1:0]] <= tx_r;
      mem_y[placed_r[AW-1:0]] <= ty_r;
      mem_z[placed_r[AW-1:0]] <= tz_r;
    end
    if (cmd.step) begin
      rx_r <= mem_x[idx_r[AW-1:0]];
      ry_r <= mem_y[idx_r[AW-1:0]];
      rz_r <= mem_z[idx_r[AW-1:0]];
    end
  end

  // compare pipeline: read -> diff -> square -> sum/compare
  function automatic logic [LW-1:0] mdist(input logic [LW-1:0] a, input logic [LW-1:0] b,
                                          input logic [LW-1:0] lq, input logic w);
    logic [LW-1:0] d;
    d = (a > b) ? a - b : b - a;
    if (!w && ({1'b0, d, 1'b0} > (LW+2)'(lq)) && d <= lq) d = lq - d;
    return d;
  endfunction

  logic          v1_r, v2_r, v3_r;
  logic [LW-1:0] dx_r, dy_r, dz_r;
  logic [2*LW-1:0] sx_r, sy_r, sz_r;
  logic [2*MW-1:0] lim2_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.step; v2_r <= v1_r; v3_r <= v2_r;
    end
    dx_r <= mdist(tx_r, rx_r, lq_x, wall_r[0]);
    dy_r <= mdist(ty_r, ry_r, lq_y, wall_r[1]);
    dz_r <= mdist(tz_r, rz_r, lq_z, wall_r[2]);
    sx_r <= dx_r * dx_r;
    sy_r <= dy_r * dy_r;
    sz_r <= dz_r * dz_r;
    lim2_r <= lim * lim;
  end

  logic [SW-1:0] sum;
  assign sum = SW'(sx_r) + SW'(sy_r) + SW'(sz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      placed_r <= '0; att_r <= '0; idx_r <= '0; ok_r <= 1'b1;
    end else begin
      if (cmd.start) begin
        idx_r <= '0; ok_r <= 1'b1;
      end
      if (cmd.step) idx_r <= idx_r + 1'b1;
      if (v3_r && ((SW > 2*MW ? SW : 2*MW)'(sum) <= (SW > 2*MW ? SW : 2*MW)'(lim2_r)))
        ok_r <= 1'b0;
      if (cmd.commit) begin
        if (att_r != ATT_MAX) att_r <= att_r + 24'd1;
        if (accept_now) placed_r <= placed_r + 1'b1;
      end
    end
  end

  assign sts.active    = active;
  assign sts.scan_none = (placed_r == '0);
  assign sts.scan_last = (idx_r + 1'b1 >= placed_r);
  assign sts.pipe_done = !cmd.step && !v1_r && !v2_r && !v3_r;

  // result word
  logic acc_r;
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.start) acc_r <= 1'b0;
    else if (cmd.commit)     acc_r <= accept_now;
  end

  assign res_accepted  = acc_r;
  assign res_x         = 18'(tx_r);
  assign res_y         = 18'(ty_r);
  assign res_z         = 18'(tz_r);
  assign res_placed    = 11'(placed_r);
  assign res_reached   = placed_r >= eff_tgt;
  assign res_exhausted = (placed_r < eff_tgt) && (att_r >= budget);

  a_placed_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    placed_r <= MAXC) else $error("placed count past capacity");
  a_commit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && accept_now |=> placed_r == $past(placed_r) + 1'b1)
    else $error("placed count not advanced");
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> idx_r < placed_r) else $error("compare beyond stored centres");

endmodule
